@@ rtl/crsfr_pkg.sv @@
// Shared types, constants and the CRC-8 step for the frame receiver.
`default_nettype none
package crsfr_pkg;

  localparam int MaxFrameBytes = 64;
  localparam int PayloadLimit  = 60;
  localparam int PosW          = $clog2(MaxFrameBytes);

  localparam logic [7:0] SyncReset       = 8'd200;
  localparam logic [5:0] MaxPayloadReset = 6'd60;
  localparam logic [7:0] CrcPoly         = 8'hD5;

  typedef enum logic [2:0] {
    StIgnored = 3'd0,
    StHeader  = 3'd1,
    StPayload = 3'd2,
    StGood    = 3'd3,
    StBadCrc  = 3'd4,
    StReject  = 3'd5,
    StType    = 3'd6
  } status_t;

  typedef enum logic {
    CfgSyncByte   = 1'b0,
    CfgMaxPayload = 1'b1
  } cfg_index_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data_byte;
    logic [PosW-1:0]  position;
    logic [7:0]       frame_address;
    logic [7:0]       frame_length;
    logic [7:0]       frame_type;
  } result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] c;
    c = crc ^ value;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/crsfr_cfg.sv @@
// Configuration registers: sync byte and payload limit.
`default_nettype none
module crsfr_cfg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic      [7:0] sync_byte,
  output logic      [5:0] max_payload
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte   <= crsfr_pkg::SyncReset;
      max_payload <= crsfr_pkg::MaxPayloadReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crsfr_pkg::CfgSyncByte:   sync_byte   <= cfg_data;
        crsfr_pkg::CfgMaxPayload: max_payload <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/crsfr_track.sv @@
// Frame tracker: position, header fields, running CRC and per-byte result.
`default_nettype none
module crsfr_track (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            sync_byte,
  input  wire logic [5:0]            max_payload,
  output crsfr_pkg::result_t         res
);

  localparam int PosW = crsfr_pkg::PosW;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic [7:0]      held_address;
  logic [7:0]      held_address_next;
  logic [7:0]      held_length;
  logic [7:0]      held_length_next;
  logic [7:0]      held_type;
  logic [7:0]      held_type_next;
  logic [7:0]      running_crc;
  logic [7:0]      running_crc_next;

  logic [5:0]      limit;
  logic [7:0]      payload_len;
  logic            is_end;
  logic [PosW:0]   pos_wide_next;
  crsfr_pkg::status_t status;
  logic            show;

  assign limit = (max_payload > 6'(crsfr_pkg::PayloadLimit)) ?
                 6'(crsfr_pkg::PayloadLimit) : max_payload;
  assign payload_len = held_length - 8'd2;
  assign is_end = ({{(9-PosW){1'b0}}, pos} == ({1'b0, held_length} + 9'd1));

  always_comb begin
    held_address_next = held_address;
    held_length_next  = held_length;
    held_type_next    = held_type;
    running_crc_next  = running_crc;
    pos_wide_next     = {1'b0, pos};
    status            = crsfr_pkg::StIgnored;
    show              = 1'b1;
    if (pos == '0) begin
      if (rx_byte == sync_byte) begin
        held_address_next = rx_byte;
        held_length_next  = 8'd0;
        held_type_next    = 8'd0;
        running_crc_next  = 8'd0;
        pos_wide_next     = (PosW+1)'(1);
        status            = crsfr_pkg::StHeader;
      end else begin
        show = 1'b0;
      end
    end else if (pos == PosW'(1)) begin
      held_length_next = rx_byte;
      pos_wide_next    = (PosW+1)'(2);
      status           = crsfr_pkg::StHeader;
    end else if (pos == PosW'(2)) begin
      held_type_next = rx_byte;
      if (held_length < 8'd2 || payload_len > {2'b00, limit}) begin
        pos_wide_next = '0;
        status        = crsfr_pkg::StReject;
      end else begin
        running_crc_next = crsfr_pkg::crc8_step(8'd0, rx_byte);
        pos_wide_next    = (PosW+1)'(3);
        status           = crsfr_pkg::StType;
      end
    end else if (is_end) begin
      status        = (rx_byte == running_crc) ? crsfr_pkg::StGood : crsfr_pkg::StBadCrc;
      pos_wide_next = '0;
    end else begin
      running_crc_next = crsfr_pkg::crc8_step(running_crc, rx_byte);
      pos_wide_next    = {1'b0, pos} + (PosW+1)'(1);
      status           = crsfr_pkg::StPayload;
    end
    if (pos_wide_next >= (PosW+1)'(crsfr_pkg::MaxFrameBytes)) begin
      pos_wide_next = '0;
      status        = crsfr_pkg::StReject;
    end
    pos_next = pos_wide_next[PosW-1:0];
  end

  always_comb begin
    res.status        = status;
    res.data_byte     = rx_byte;
    res.position      = show ? pos : '0;
    res.frame_address = show ? held_address_next : 8'd0;
    res.frame_length  = show ? held_length_next : 8'd0;
    res.frame_type    = show ? held_type_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      held_address <= 8'd0;
      held_length  <= 8'd0;
      held_type    <= 8'd0;
      running_crc  <= 8'd0;
    end else if (accept) begin
      pos          <= pos_next;
      held_address <= held_address_next;
      held_length  <= held_length_next;
      held_type    <= held_type_next;
      running_crc  <= running_crc_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crsfr_out.sv @@
// Result register with valid/stall handshake toward the consumer.
`default_nettype none
module crsfr_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  crsfr_pkg::result_t res,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_stall,
  output crsfr_pkg::result_t held
);

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crsf_frame_receiver_crc8_unit.sv @@
// Top level of the CRSF frame receiver with CRC-8 check.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   rx_byte
//  out      source     out_valid / out_stall status, data_byte, position,
//                                            frame_address, frame_length, frame_type
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle unless stalled; each result is registered in the next cycle.
// The frame update and CRC step sit between the input port and the result register.
// Reset is synchronous: receiver idle, sync byte 200, payload limit 60.
// A stalled result blocks input only while the result register is full.
`default_nettype none
module crsf_frame_receiver_crc8_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] status,
  output logic      [7:0] data_byte,
  output logic      [5:0] position,
  output logic      [7:0] frame_address,
  output logic      [7:0] frame_length,
  output logic      [7:0] frame_type,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0]         sync_byte;
  logic [5:0]         max_payload;
  logic               accept;
  logic               busy;
  crsfr_pkg::result_t res;
  crsfr_pkg::result_t held;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  crsfr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sync_byte   (sync_byte),
    .max_payload (max_payload)
  );

  crsfr_track u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .sync_byte   (sync_byte),
    .max_payload (max_payload),
    .res         (res)
  );

  crsfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign status        = held.status;
  assign data_byte     = held.data_byte;
  assign position      = held.position;
  assign frame_address = held.frame_address;
  assign frame_length  = held.frame_length;
  assign frame_type    = held.frame_type;

endmodule
`default_nettype wire
